[src/usd_pkg.sv]
// usd_pkg: shared types, codes and constants for the utf stream decoder
// used by usd_front, usd_queue, usd_back and utf_stream_decoder_unit
`timescale 1ns / 1ps

package usd_pkg;

    // default depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_FORMAT = 1'b0,
        CFG_STRICT_MODE   = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        FMT_UTF8    = 3'd0,
        FMT_UTF16LE = 3'd1,
        FMT_UTF16BE = 3'd2,
        FMT_UTF32LE = 3'd3,
        FMT_UTF32BE = 3'd4
    } t_fmt;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ILLEGAL   = 2'd1,
        ST_TRUNC     = 2'd2,
        ST_AFTER_ERR = 2'd3
    } t_status;

    // utf-16 unit tags: top six bits of a high or low surrogate
    localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;
    // 0xd800..0xdfff shifted right by 11
    localparam logic [20:0] SURR_BLOCK    = 21'h00001B;
    localparam logic [20:0] SUPP_BASE     = 21'h010000;

    localparam logic [7:0] LEAD_MIN_LEGAL = 8'hC2;
    localparam logic [7:0] LEAD_MAX_LEGAL = 8'hF4;
    localparam logic [7:0] LEAD_E0        = 8'hE0;
    localparam logic [7:0] LEAD_F0        = 8'hF0;
    localparam logic [7:0] LEAD_F4        = 8'hF4;

    // one classified source byte
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_ascii;   // below 0x80
        logic       is_cont;    // 0x80..0xbf
        logic       is_hi;      // 0xc0 and up
        logic [2:0] lead_len;
        logic [4:0] lead_bits;
        logic       lead_bad;
        logic       is_e0;
        logic       is_f0;
        logic       is_f4;
        logic       lt_a0;
        logic       lt_90;
        logic       gt_8f;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_item_xfer;

    typedef struct packed {
        logic [31:0] code_point;
        t_status     status;
        logic        eob;
    } t_result;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

[src/usd_front.sv]
// usd_front: takes the input request and classifies the byte for the back end
// depends on usd_pkg
`timescale 1ns / 1ps

module usd_front (
    input  logic              i_in_valid,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  logic              i_full,
    output logic              o_in_stall,
    output usd_pkg::t_item_xfer o_push
);

    logic [7:0] b;
    usd_pkg::t_item it;

    assign b = i_data_byte;

    always_comb begin
        it           = '0;
        it.data      = b;
        it.last      = i_last_byte;
        it.is_ascii  = (b[7] == 1'b0);
        it.is_cont   = (b[7:6] == 2'b10);
        it.is_hi     = (b[7:6] == 2'b11);
        it.is_e0     = (b == usd_pkg::LEAD_E0);
        it.is_f0     = (b == usd_pkg::LEAD_F0);
        it.is_f4     = (b == usd_pkg::LEAD_F4);
        it.lt_a0     = (b < 8'hA0);
        it.lt_90     = (b < 8'h90);
        it.gt_8f     = (b > 8'h8F);
        it.lead_bad  = (b < usd_pkg::LEAD_MIN_LEGAL) || (b > usd_pkg::LEAD_MAX_LEGAL);
        if (b inside {[8'hC0:8'hDF]}) begin
            it.lead_len  = 3'd2;
            it.lead_bits = b[4:0];
        end else if (b inside {[8'hE0:8'hEF]}) begin
            it.lead_len  = 3'd3;
            it.lead_bits = {1'b0, b[3:0]};
        end else if (b inside {[8'hF0:8'hF7]}) begin
            it.lead_len  = 3'd4;
            it.lead_bits = {2'b00, b[2:0]};
        end else if (b inside {[8'hF8:8'hFB]}) begin
            it.lead_len  = 3'd5;
            it.lead_bits = {3'b000, b[1:0]};
        end else begin
            it.lead_len  = 3'd6;
            it.lead_bits = {4'b0000, b[0]};
        end
    end

    assign o_in_stall   = i_full;
    assign o_push.valid = i_in_valid && !i_full;
    assign o_push.item  = it;

endmodule

[src/usd_queue.sv]
// usd_queue: short fifo of classified bytes between front and back
// depends on usd_pkg
`timescale 1ns / 1ps

module usd_queue #(
    parameter int unsigned Depth = usd_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  usd_pkg::t_item_xfer i_push,
    output logic                o_full,
    input  logic                i_pop,
    output usd_pkg::t_item_xfer o_head
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    usd_pkg::t_item r_mem [Depth];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            push;
    logic            pop;

    assign push = i_push.valid && !o_full;
    assign pop  = i_pop && (r_cnt != '0);

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        if (push) begin
            n_wr = (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + PtrW'(1);
        end
        if (pop) begin
            n_rd = (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + PtrW'(1);
        end
        n_cnt = r_cnt + CntW'(push) - CntW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push.item;
        end
    end

    assign o_full       = (r_cnt == CntW'(Depth));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_mem[r_rd];

endmodule

[src/usd_back.sv]
// usd_back: decode state, configuration registers and the two-entry result buffer
// depends on usd_pkg
`timescale 1ns / 1ps

module usd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  usd_pkg::t_cfg_wr    i_cfg,
    input  usd_pkg::t_item_xfer i_head,
    output logic                o_pop,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output usd_pkg::t_result    o_result
);

    // configuration
    logic [2:0]  r_fmt;
    logic        r_strict;

    // decode state
    logic [31:0] r_asm, n_asm;
    logic        r_bad, n_bad;
    logic        r_e0, n_e0;
    logic        r_f0, n_f0;
    logic        r_f4, n_f4;
    logic [2:0]  r_cnt, n_cnt;
    logic [2:0]  r_exp, n_exp;
    logic        r_pv, n_pv;
    logic [9:0]  r_ph, n_ph;
    logic        r_disc, n_disc;

    // result buffer
    usd_pkg::t_result r_ob [2];
    usd_pkg::t_result n_ob [2];
    logic [1:0]  r_ob_cnt, n_ob_cnt;

    usd_pkg::t_item   it;
    usd_pkg::t_result res0, res1, emit;
    logic [1:0]  nres;
    logic        clr;
    logic        bad_b;
    logic        u8_bad;
    logic [2:0]  cnt_inc;
    logic [20:0] payload;
    logic [15:0] u16;
    logic [31:0] w32;
    logic [1:0]  k32;
    logic        u_low;
    logic        u_high;
    logic        pop;
    logic [1:0]  free;
    logic        go;
    logic [1:0]  base_cnt;

    assign it      = i_head.item;
    assign cnt_inc = r_cnt + 3'd1;
    assign payload = {r_asm[14:0], it.data[5:0]};
    assign u16     = (r_fmt == usd_pkg::FMT_UTF16BE) ? {r_asm[7:0], it.data}
                                                     : {it.data, r_asm[7:0]};
    assign u_low   = (u16[15:10] == usd_pkg::SURR_LOW_TAG);
    assign u_high  = (u16[15:10] == usd_pkg::SURR_HIGH_TAG);
    assign k32     = r_cnt[1:0];
    assign w32     = (r_fmt == usd_pkg::FMT_UTF32BE) ? {r_asm[23:0], it.data}
                   : (r_asm | ({24'd0, it.data} << {k32, 3'b000}));

    // second-byte range depends on the lead; later bytes must be continuation bytes
    always_comb begin
        if (it.is_hi) begin
            bad_b = 1'b1;
        end else if (r_cnt != 3'd1) begin
            bad_b = !it.is_cont;
        end else if (r_e0) begin
            bad_b = it.lt_a0;
        end else if (r_f0) begin
            bad_b = it.lt_90;
        end else if (r_f4) begin
            bad_b = it.gt_8f;
        end else begin
            bad_b = it.is_ascii;
        end
    end

    assign u8_bad = r_bad || bad_b;

    always_comb begin
        n_asm  = r_asm;
        n_bad  = r_bad;
        n_e0   = r_e0;
        n_f0   = r_f0;
        n_f4   = r_f4;
        n_cnt  = r_cnt;
        n_exp  = r_exp;
        n_pv   = r_pv;
        n_ph   = r_ph;
        n_disc = r_disc;
        res0   = '0;
        res1   = '0;
        emit   = '0;
        nres   = 2'd0;
        clr    = 1'b0;

        if (r_disc) begin
            if (it.last) begin
                res0.status = usd_pkg::ST_AFTER_ERR;
                nres        = 2'd1;
            end
        end else begin
            case (r_fmt)
                usd_pkg::FMT_UTF8: begin
                    if (r_cnt == 3'd0) begin
                        if (it.is_ascii) begin
                            res0.code_point = {24'd0, it.data};
                            res0.status     = usd_pkg::ST_OK;
                            nres            = 2'd1;
                        end else if (it.is_cont) begin
                            res0.status = usd_pkg::ST_ILLEGAL;
                            nres        = 2'd1;
                            clr         = 1'b1;
                            n_disc      = 1'b1;
                        end else begin
                            n_asm = {27'd0, it.lead_bits};
                            n_bad = it.lead_bad;
                            n_e0  = it.is_e0;
                            n_f0  = it.is_f0;
                            n_f4  = it.is_f4;
                            n_exp = it.lead_len;
                            n_cnt = 3'd1;
                        end
                    end else begin
                        n_asm = {11'd0, payload};
                        n_bad = u8_bad;
                        n_cnt = cnt_inc;
                        if (cnt_inc >= r_exp) begin
                            clr  = 1'b1;
                            nres = 2'd1;
                            if (u8_bad) begin
                                res0.status = usd_pkg::ST_ILLEGAL;
                                n_disc      = 1'b1;
                            end else begin
                                res0.code_point = {11'd0, payload};
                                res0.status     = usd_pkg::ST_OK;
                            end
                        end
                    end
                end
                usd_pkg::FMT_UTF16LE, usd_pkg::FMT_UTF16BE: begin
                    if (r_cnt == 3'd0) begin
                        n_asm = {24'd0, it.data};
                        n_cnt = 3'd1;
                    end else begin
                        n_asm = '0;
                        n_cnt = 3'd0;
                        n_pv  = 1'b0;
                        if (r_pv && u_low) begin
                            res0.code_point = {11'd0, usd_pkg::SUPP_BASE + {r_ph, u16[9:0]}};
                            res0.status     = usd_pkg::ST_OK;
                            nres            = 2'd1;
                        end else if (r_pv && r_strict) begin
                            res0.status = usd_pkg::ST_ILLEGAL;
                            nres        = 2'd1;
                            clr         = 1'b1;
                            n_disc      = 1'b1;
                        end else begin
                            // lenient unpaired high goes out first, the unit then stands alone
                            if (r_pv) begin
                                res0.code_point = {16'd0, usd_pkg::SURR_HIGH_TAG, r_ph};
                                res0.status     = usd_pkg::ST_OK;
                                nres            = 2'd1;
                            end
                            if (u_high) begin
                                n_pv = 1'b1;
                                n_ph = u16[9:0];
                            end else begin
                                if (r_strict && u_low) begin
                                    emit.status = usd_pkg::ST_ILLEGAL;
                                    clr         = 1'b1;
                                    n_disc      = 1'b1;
                                end else begin
                                    emit.code_point = {16'd0, u16};
                                    emit.status     = usd_pkg::ST_OK;
                                end
                                if (nres == 2'd0) begin
                                    res0 = emit;
                                end else begin
                                    res1 = emit;
                                end
                                nres = nres + 2'd1;
                            end
                        end
                    end
                end
                usd_pkg::FMT_UTF32LE, usd_pkg::FMT_UTF32BE: begin
                    n_asm = w32;
                    if (k32 != 2'd3) begin
                        n_cnt = {1'b0, k32} + 3'd1;
                    end else begin
                        clr  = 1'b1;
                        nres = 2'd1;
                        if (r_strict && (w32[31:11] == usd_pkg::SURR_BLOCK)) begin
                            res0.status = usd_pkg::ST_ILLEGAL;
                            n_disc      = 1'b1;
                        end else begin
                            res0.code_point = w32;
                            res0.status     = usd_pkg::ST_OK;
                        end
                    end
                end
                default: begin
                    res0.status = usd_pkg::ST_ILLEGAL;
                    nres        = 2'd1;
                    clr         = 1'b1;
                    n_disc      = 1'b1;
                end
            endcase

            if (clr) begin
                n_asm = '0;
                n_bad = 1'b0;
                n_e0  = 1'b0;
                n_f0  = 1'b0;
                n_f4  = 1'b0;
                n_cnt = 3'd0;
                n_exp = 3'd0;
                n_pv  = 1'b0;
                n_ph  = '0;
            end

            // buffer ends inside a sequence or after a high surrogate
            if (it.last && !n_disc && ((n_cnt != 3'd0) || n_pv)) begin
                if (nres == 2'd0) begin
                    res0.status = usd_pkg::ST_TRUNC;
                end else begin
                    res1.status = usd_pkg::ST_TRUNC;
                end
                nres = nres + 2'd1;
            end
        end

        res0.eob = it.last && (nres == 2'd1);
        res1.eob = it.last && (nres == 2'd2);

        if (it.last) begin
            n_asm  = '0;
            n_bad  = 1'b0;
            n_e0   = 1'b0;
            n_f0   = 1'b0;
            n_f4   = 1'b0;
            n_cnt  = 3'd0;
            n_exp  = 3'd0;
            n_pv   = 1'b0;
            n_ph   = '0;
            n_disc = 1'b0;
        end
    end

    // take the next byte only when the buffer has room for all its results
    assign pop      = (r_ob_cnt != 2'd0) && !i_out_stall;
    assign free     = 2'd2 - r_ob_cnt + {1'b0, pop};
    assign go       = i_head.valid && (nres <= free);
    assign base_cnt = r_ob_cnt - {1'b0, pop};

    always_comb begin
        n_ob[0]  = pop ? r_ob[1] : r_ob[0];
        n_ob[1]  = r_ob[1];
        n_ob_cnt = base_cnt;
        if (go) begin
            case (base_cnt)
                2'd0: begin
                    n_ob[0] = res0;
                    n_ob[1] = res1;
                end
                2'd1: begin
                    n_ob[1] = res0;
                end
                default: begin
                end
            endcase
            n_ob_cnt = base_cnt + nres;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= usd_pkg::FMT_UTF8;
            r_strict <= 1'b0;
            r_asm    <= '0;
            r_bad    <= 1'b0;
            r_e0     <= 1'b0;
            r_f0     <= 1'b0;
            r_f4     <= 1'b0;
            r_cnt    <= '0;
            r_exp    <= '0;
            r_pv     <= 1'b0;
            r_ph     <= '0;
            r_disc   <= 1'b0;
            r_ob_cnt <= '0;
        end else begin
            r_ob_cnt <= n_ob_cnt;
            if (i_cfg.valid && (i_cfg.index == usd_pkg::CFG_SOURCE_FORMAT)) begin
                r_fmt  <= i_cfg.data;
                r_asm  <= '0;
                r_bad  <= 1'b0;
                r_e0   <= 1'b0;
                r_f0   <= 1'b0;
                r_f4   <= 1'b0;
                r_cnt  <= '0;
                r_exp  <= '0;
                r_pv   <= 1'b0;
                r_ph   <= '0;
                r_disc <= 1'b0;
            end else begin
                if (i_cfg.valid && (i_cfg.index == usd_pkg::CFG_STRICT_MODE)) begin
                    r_strict <= i_cfg.data[0];
                end
                if (go) begin
                    r_asm  <= n_asm;
                    r_bad  <= n_bad;
                    r_e0   <= n_e0;
                    r_f0   <= n_f0;
                    r_f4   <= n_f4;
                    r_cnt  <= n_cnt;
                    r_exp  <= n_exp;
                    r_pv   <= n_pv;
                    r_ph   <= n_ph;
                    r_disc <= n_disc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ob[0] <= n_ob[0];
        r_ob[1] <= n_ob[1];
    end

    assign o_pop       = go;
    assign o_out_valid = (r_ob_cnt != 2'd0);
    assign o_result    = r_ob[0];

endmodule

[src/utf_stream_decoder_unit.sv]
// utf_stream_decoder_unit: top level, byte stream in, code points out
// depends on usd_pkg, usd_front, usd_queue and usd_back
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | sink      | i_in_valid / o_in_stall    | i_data_byte, i_last_byte
//  out     | source    | o_out_valid / i_out_stall  | o_code_point, o_status, o_end_of_buffer
//  cfg     | sink      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one byte per cycle sustained while the output is not stalled and each byte yields
// at most one result; a result is registered in the queue and then in the result buffer
// a byte that yields two results holds the back end until the two-entry result
// buffer has room for both, which sets the rate under output stalls
// o_in_stall is the queue-full flag, so the input side keeps flowing while a
// result waits; reset is synchronous and clears queue, decode state and buffer
`timescale 1ns / 1ps

module utf_stream_decoder_unit #(
    parameter int unsigned QueueDepth = usd_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_last_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [31:0]                    o_code_point,
    output logic [1:0]                     o_status,
    output logic                           o_end_of_buffer,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [usd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [usd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    usd_pkg::t_item_xfer push;
    usd_pkg::t_item_xfer q_head;
    usd_pkg::t_cfg_wr    cfg;
    usd_pkg::t_result    result;
    logic                q_full;
    logic                back_pop;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    usd_front u_front (
        .i_in_valid  (i_in_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_full      (q_full),
        .o_in_stall  (o_in_stall),
        .o_push      (push)
    );

    usd_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_head  (q_head)
    );

    usd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_head      (q_head),
        .o_pop       (back_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_code_point    = result.code_point;
    assign o_status        = result.status;
    assign o_end_of_buffer = result.eob;

    // the back end never takes a byte the queue does not hold
    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_pop |-> q_head.valid)
        else $error("back end popped an empty queue");

    // after reset the result buffer is empty
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending right after reset");

    // truncated and ended-after-error results only come from the last byte
    a_trunc_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == usd_pkg::ST_TRUNC)) |-> o_end_of_buffer)
        else $error("truncated result without end of buffer");

    a_after_err_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == usd_pkg::ST_AFTER_ERR)) |-> o_end_of_buffer)
        else $error("after-error result without end of buffer");

endmodule
